### rtl/pmcr_pkg.sv
// pmcr_pkg: types and constants shared by the mac clone rewriter modules
// no dependencies
package pmcr_pkg;

  localparam int unsigned AddrBytes = 6;
  localparam int unsigned HdrBytes  = 2 * AddrBytes + 2;
  localparam int unsigned PosW      = 4;
  localparam int unsigned AddrW     = 8 * AddrBytes;
  localparam int unsigned CfgIdxW   = 8;

  localparam logic [15:0] EtypeDiscovery = 16'h8863;
  localparam logic [15:0] EtypeSession   = 16'h8864;

  localparam logic [CfgIdxW-1:0] CfgCloneEnable  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgCloneAddress = CfgIdxW'(1);

  localparam logic [PosW-1:0] PosPass    = PosW'(HdrBytes);
  localparam logic [PosW-1:0] PosLastHdr = PosW'(HdrBytes - 1);
  localparam logic [PosW-1:0] PosSrc     = PosW'(AddrBytes);
  localparam logic [PosW-1:0] PosSrcEnd  = PosW'(2 * AddrBytes - 1);
  localparam logic [PosW-1:0] PosDstEnd  = PosW'(AddrBytes - 1);

  typedef struct packed {
    logic       direction;
    logic [7:0] in_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_frame_end;
    logic       out_direction;
    logic       run_last;
  } out_word_t;

  typedef enum logic [1:0] {
    RW_NONE = 2'd0,
    RW_SRC  = 2'd1,
    RW_DST  = 2'd2
  } rewrite_e;

  typedef struct packed {
    logic             is_hdr;
    logic [7:0]       data;
    logic             frame_end;
    logic             direction;
    logic [PosW-1:0]  last_idx;
    rewrite_e         mode;
    logic [AddrW-1:0] addr;
  } cmd_t;

  function automatic logic [7:0] addr_byte(logic [AddrW-1:0] addr, logic [PosW-1:0] k);
    logic [7:0] b;
    b = 8'h00;
    for (int i = 0; i < AddrBytes; i++) begin
      if (k == PosW'(i)) begin
        b = addr[8*(AddrBytes-1-i) +: 8];
      end
    end
    return b;
  endfunction

endpackage

### rtl/pmcr_fifo.sv
// pmcr_fifo: small register queue between the front and back parts
// no dependencies
module pmcr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/pmcr_front.sv
// pmcr_front: accepts frame words, holds the header, decides the rewrite
// depends on pmcr_pkg
module pmcr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pmcr_pkg::in_word_t            in_word_i,
  input  logic                          cfg_valid_i,
  input  logic [pmcr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pmcr_pkg::AddrW-1:0]    cfg_data_i,
  output logic                          push_o,
  output pmcr_pkg::cmd_t                cmd_o,
  input  logic                          q_full_i,
  input  logic                          hdr_done_i,
  input  logic [pmcr_pkg::PosW-1:0]     rd_idx_i,
  output logic [7:0]                    rd_byte_o
);

  logic [7:0]                   store_q [pmcr_pkg::HdrBytes];
  logic [pmcr_pkg::PosW-1:0]    pos_q, pos_d;
  logic                         path_q, path_d;
  logic [pmcr_pkg::AddrW-1:0]   saved_q, saved_d;
  logic                         lock_q, lock_d;
  logic                         en_q;
  logic [pmcr_pkg::AddrW-1:0]   clone_q;
  logic                         accept, passing, complete, hit;
  logic [15:0]                  etype;
  logic [pmcr_pkg::AddrW-1:0]   dst_addr, src_addr;

  assign passing    = (pos_q == pmcr_pkg::PosPass);
  assign in_ready_o = !q_full_i && !(lock_q && !passing);
  assign accept     = in_valid_i && in_ready_o;
  assign rd_byte_o  = store_q[rd_idx_i];

  always_comb begin
    for (int i = 0; i < pmcr_pkg::AddrBytes; i++) begin
      dst_addr[8*(pmcr_pkg::AddrBytes-1-i) +: 8] = store_q[i];
      src_addr[8*(pmcr_pkg::AddrBytes-1-i) +: 8] = store_q[pmcr_pkg::AddrBytes + i];
    end
  end

  assign etype    = {store_q[2 * pmcr_pkg::AddrBytes], in_word_i.in_byte};
  assign hit      = en_q && (etype inside {pmcr_pkg::EtypeDiscovery,
                                           pmcr_pkg::EtypeSession});
  assign complete = (pos_q == pmcr_pkg::PosLastHdr) || in_word_i.frame_end;

  always_comb begin
    pos_d        = pos_q;
    path_d       = path_q;
    saved_d      = saved_q;
    lock_d       = lock_q && !hdr_done_i;
    push_o       = 1'b0;
    cmd_o        = '0;
    cmd_o.data      = in_word_i.in_byte;
    cmd_o.frame_end = in_word_i.frame_end;
    cmd_o.direction = path_q;
    cmd_o.last_idx  = pos_q;
    cmd_o.mode      = pmcr_pkg::RW_NONE;
    if (accept) begin
      if (passing) begin
        push_o = 1'b1;
        if (in_word_i.frame_end) begin
          pos_d = '0;
        end
      end else begin
        if (pos_q == '0) begin
          path_d          = in_word_i.direction;
          cmd_o.direction = in_word_i.direction;
        end
        if (complete) begin
          push_o       = 1'b1;
          lock_d       = 1'b1;
          cmd_o.is_hdr = 1'b1;
          pos_d        = in_word_i.frame_end ? '0 : pmcr_pkg::PosPass;
          if (pos_q == pmcr_pkg::PosLastHdr && hit) begin
            if (!path_q) begin
              cmd_o.mode = pmcr_pkg::RW_SRC;
              cmd_o.addr = clone_q;
              saved_d    = src_addr;
            end else if (dst_addr == clone_q) begin
              cmd_o.mode = pmcr_pkg::RW_DST;
              cmd_o.addr = saved_q;
            end
          end
        end else begin
          pos_d = pos_q + pmcr_pkg::PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      path_q  <= 1'b0;
      saved_q <= '0;
      lock_q  <= 1'b0;
      en_q    <= 1'b0;
      clone_q <= '0;
    end else begin
      pos_q   <= pos_d;
      path_q  <= path_d;
      saved_q <= saved_d;
      lock_q  <= lock_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == pmcr_pkg::CfgCloneEnable) begin
          en_q <= cfg_data_i[0];
        end else if (cfg_index_i == pmcr_pkg::CfgCloneAddress) begin
          clone_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !passing) begin
      store_q[pos_q] <= in_word_i.in_byte;
    end
  end

endmodule

### rtl/pmcr_back.sv
// pmcr_back: executes queued commands, releases headers with rewrite
// depends on pmcr_pkg
module pmcr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  pmcr_pkg::cmd_t             cmd_i,
  output logic                       pop_o,
  output logic                       hdr_done_o,
  output logic [pmcr_pkg::PosW-1:0]  rd_idx_o,
  input  logic [7:0]                 rd_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pmcr_pkg::out_word_t        out_word_o
);

  logic [pmcr_pkg::PosW-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  pmcr_pkg::out_word_t       out_q, out_d;
  logic                      fire, last;
  logic [7:0]                hdr_byte;

  assign rd_idx_o    = idx_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign fire        = q_valid_i && (!out_valid_q || out_ready_i);
  assign last        = !cmd_i.is_hdr || (idx_q == cmd_i.last_idx);
  assign pop_o       = fire && last;
  assign hdr_done_o  = fire && last && cmd_i.is_hdr;

  always_comb begin
    hdr_byte = rd_byte_i;
    case (cmd_i.mode)
      pmcr_pkg::RW_SRC: begin
        if (idx_q inside {[pmcr_pkg::PosSrc:pmcr_pkg::PosSrcEnd]}) begin
          hdr_byte = pmcr_pkg::addr_byte(cmd_i.addr, idx_q - pmcr_pkg::PosSrc);
        end
      end
      pmcr_pkg::RW_DST: begin
        if (idx_q <= pmcr_pkg::PosDstEnd) begin
          hdr_byte = pmcr_pkg::addr_byte(cmd_i.addr, idx_q);
        end
      end
      default: hdr_byte = rd_byte_i;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire) begin
      out_valid_d           = 1'b1;
      out_d.out_byte        = cmd_i.is_hdr ? hdr_byte : cmd_i.data;
      out_d.out_frame_end   = cmd_i.frame_end && last;
      out_d.out_direction   = cmd_i.direction;
      out_d.run_last        = last;
      if (cmd_i.is_hdr) begin
        idx_d = last ? '0 : idx_q + pmcr_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

### rtl/pppoe_mac_clone_rewriter_unit.sv
// pppoe_mac_clone_rewriter_unit: top level of the pppoe mac clone rewriter
// depends on pmcr_pkg, pmcr_front, pmcr_fifo, pmcr_back
//
// Frame bytes arrive one word per cycle while in_ready_o is high. The 14
// header bytes are held in the front part and accepted at one word per cycle
// without results; the back part then releases the header at one word per
// cycle while the output is free or taken, with the source or destination
// address rewritten for pppoe ethertypes when cloning is on. Payload bytes
// pass at one word per cycle unless the queue or output stalls. The next
// frame's header bytes wait until the previous header release is done, and
// payload bytes wait behind the release in the short queue, so the single
// header store and queue depth slow each frame. Results leave through an
// output register; a command queue of QueueDepth entries decouples both sides.
module pppoe_mac_clone_rewriter_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pmcr_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pmcr_pkg::out_word_t           out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pmcr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pmcr_pkg::AddrW-1:0]    cfg_data_i
);

  localparam int unsigned CmdW = $bits(pmcr_pkg::cmd_t);

  pmcr_pkg::cmd_t            push_cmd, head_cmd;
  logic [CmdW-1:0]           head_bits;
  logic                      push, q_full, q_valid, pop, hdr_done;
  logic [pmcr_pkg::PosW-1:0] rd_idx;
  logic [7:0]                rd_byte;

  assign cfg_ready_o = 1'b1;
  assign head_cmd    = pmcr_pkg::cmd_t'(head_bits);

  pmcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .q_full_i    (q_full),
    .hdr_done_i  (hdr_done),
    .rd_idx_i    (rd_idx),
    .rd_byte_o   (rd_byte)
  );

  pmcr_fifo #(
    .Width (CmdW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_bits)
  );

  pmcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .hdr_done_o  (hdr_done),
    .rd_idx_o    (rd_idx),
    .rd_byte_i   (rd_byte),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
